### design/stdr_pkg.sv
// Shared types and constants for the scanline triangle depth rasterizer.
`timescale 1ns / 1ps
package stdr_pkg;
  localparam int DW = 64;
  localparam int DEF_MAX_WIDTH = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGEN_THR = 2'd2;

  localparam logic [6:0] SIZE_RESET = 7'd64;
  localparam logic [16:0] THR_RESET = 17'd64;

  localparam logic [15:0] DEPTH_FAR = 16'hFFFF;
  localparam logic [16:0] UNPACK_MUL = 17'd65537;
  localparam logic [15:0] PACK_MUL = 16'd65535;

  typedef struct packed {
    logic [15:0] depth;
    logic [31:0] color;
  } pix_t;
endpackage

### design/stdr_mul.sv
// Shift-add multiplier returning the low word of a signed product.
`timescale 1ns / 1ps
module stdr_mul import stdr_pkg::*; #(
  parameter int W = DW
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic                done,
  output logic signed [W-1:0] product
);
  logic         run;
  logic         neg;
  logic [W-1:0] acc;
  logic [W-1:0] mcand;
  logic [W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        acc <= '0;
        mcand <= a;
        mplier <= b[W-1] ? (~b + 1'b1) : b;
        neg <= b[W-1];
      end else if (run) begin
        if (mplier == '0) begin
          run <= 1'b0;
          done <= 1'b1;
          product <= neg ? (~acc + 1'b1) : acc;
        end else begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
        end
      end
    end
  end
endmodule

### design/stdr_div.sv
// Restoring divider: signed dividend by positive divisor, truncating toward zero.
`timescale 1ns / 1ps
module stdr_div import stdr_pkg::*; #(
  parameter int W = DW
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic signed [W-1:0] divisor,
  output logic                done,
  output logic signed [W-1:0] quotient
);
  localparam int CW = $clog2(W);

  logic          run;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  num;
  logic [W-1:0]  dvs;
  logic [W:0]    rem_sh;
  logic          qbit;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  num_next;

  always_comb begin
    rem_sh = {rem, num[W-1]};
    qbit = rem_sh >= {1'b0, dvs};
    rem_next = qbit ? W'(rem_sh - {1'b0, dvs}) : rem_sh[W-1:0];
    num_next = {num[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W - 1);
        rem <= '0;
        num <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
        dvs <= divisor;
        neg <= dividend[W-1];
      end else if (run) begin
        rem <= rem_next;
        num <= num_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run <= 1'b0;
          done <= 1'b1;
          quotient <= neg ? (~num_next + 1'b1) : num_next;
        end
      end
    end
  end
endmodule

### design/stdr_mem.sv
// Pixel store holding depth and color, one write and one registered read port.
`timescale 1ns / 1ps
module stdr_mem import stdr_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  pix_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output pix_t          rd_data
);
  pix_t store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end
endmodule

### design/scanline_triangle_depth_raster.sv
// Top level of the scanline triangle rasterizer with depth and color stores.
//
// A request is taken when start is high and busy is low. mode selects clear,
// draw triangle or read pixel; mode 3 does nothing. Every request gives one
// result, shown for one cycle with done high: read_color and read_depth for a
// read (zero otherwise) and rejected for a dropped triangle. The receiver
// cannot hold results off, and the block never stalls on it.
// Clear writes frame_width * frame_height store entries, each size clamped
// to 1..MAX, one store entry a cycle. A read passes through the READ and
// RDCAP states. A draw runs its setup through a shared 64-step divider (up to
// three divisions), then per row six multiplies on a shift-add unit whose
// length follows the multiplier operand, one division and one more multiply
// per span that is not skipped, and one pixel per cycle in the span, so the
// length of a draw is set by its height and area. A triangle is rejected in
// BBOX or, after the three SORT states, in HEIGHT. Configuration writes
// through cfg_write, cfg_index and cfg_data take effect at once; they are
// to be made only while the block is idle, which the block does not enforce.
// After reset the block sweeps the whole store, one entry a cycle, busy high.
`timescale 1ns / 1ps
module scanline_triangle_depth_raster import stdr_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           mode,
  input  logic signed [31:0]   vert_a_x,
  input  logic signed [31:0]   vert_a_y,
  input  logic signed [31:0]   vert_a_z,
  input  logic signed [31:0]   vert_b_x,
  input  logic signed [31:0]   vert_b_y,
  input  logic signed [31:0]   vert_b_z,
  input  logic signed [31:0]   vert_c_x,
  input  logic signed [31:0]   vert_c_y,
  input  logic signed [31:0]   vert_c_z,
  input  logic [31:0]          fill_color,
  input  logic [11:0]          read_index,
  output logic [31:0]          read_color,
  output logic [15:0]          read_depth,
  output logic                 rejected
);
  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int F = FRAC_BITS;
  localparam logic signed [DW-1:0] UNIT = DW'(1) << F;
  localparam logic signed [DW-1:0] DIV_ONE = DW'(1) << (2 * F);
  localparam logic signed [DW-1:0] STEP_LIM = DW'(1) << (60 - F);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_INIT = 5'd1;
  localparam logic [4:0] ST_CLEAR = 5'd2;
  localparam logic [4:0] ST_READ = 5'd3;
  localparam logic [4:0] ST_RDCAP = 5'd4;
  localparam logic [4:0] ST_BBOX = 5'd5;
  localparam logic [4:0] ST_SORT0 = 5'd6;
  localparam logic [4:0] ST_SORT1 = 5'd7;
  localparam logic [4:0] ST_SORT2 = 5'd8;
  localparam logic [4:0] ST_HEIGHT = 5'd9;
  localparam logic [4:0] ST_DIVA = 5'd10;
  localparam logic [4:0] ST_DIVB = 5'd11;
  localparam logic [4:0] ST_DIVC = 5'd12;
  localparam logic [4:0] ST_HALF = 5'd13;
  localparam logic [4:0] ST_MULA = 5'd14;
  localparam logic [4:0] ST_MULB = 5'd15;
  localparam logic [4:0] ST_MSX = 5'd16;
  localparam logic [4:0] ST_MSZ = 5'd17;
  localparam logic [4:0] ST_MEX = 5'd18;
  localparam logic [4:0] ST_MEZ = 5'd19;
  localparam logic [4:0] ST_SPAN = 5'd20;
  localparam logic [4:0] ST_DIVS = 5'd21;
  localparam logic [4:0] ST_RANGE = 5'd22;
  localparam logic [4:0] ST_MULD = 5'd23;
  localparam logic [4:0] ST_PIX = 5'd24;
  localparam logic [4:0] ST_NEXT = 5'd25;
  localparam logic [4:0] ST_DONE = 5'd26;

  logic [4:0] state;
  logic       op_wait;
  logic       half;

  logic [6:0]  frame_width;
  logic [6:0]  frame_height;
  logic [16:0] degenerate_threshold;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic signed [DW-1:0] w_s;
  logic signed [DW-1:0] h_s;
  logic signed [DW-1:0] thr;
  logic [WW+HW-1:0] clr_n;

  logic signed [DW-1:0] vx [3];
  logic signed [DW-1:0] vy [3];
  logic signed [DW-1:0] vz [3];
  logic [31:0] color;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] clr_last;
  logic [AW-1:0] rd_idx;
  logic          rd_ok;
  logic [AW+11:0] rd_ext;

  logic signed [DW-1:0] astep;
  logic signed [DW-1:0] bstep_top;
  logic signed [DW-1:0] bstep_bot;
  logic signed [DW-1:0] y_cur;
  logic signed [DW-1:0] y_end;
  logic signed [DW-1:0] alpha;
  logic signed [DW-1:0] beta;
  logic signed [DW-1:0] sx;
  logic signed [DW-1:0] sz;
  logic signed [DW-1:0] ex;
  logic signed [DW-1:0] ez;
  logic signed [DW-1:0] step;
  logic signed [DW-1:0] d_cur;
  logic [WW-1:0] i_cur;
  logic [WW-1:0] i_end;
  logic [AW-1:0] line_addr;

  logic signed [DW-1:0] minx, maxx, miny, maxy;
  logic bbox_out;
  logic [1:0] sp, sq;
  logic do_swap;
  logic signed [DW-1:0] dyt, dytop, dybot;
  logic signed [DW-1:0] ytop, h_ylo, h_yhi, h_rx, h_rz, h_dxr, h_dzr, h_bstep;
  logic signed [DW-1:0] y_lo_c, y_hi_c;
  logic signed [DW-1:0] s_x, s_z, e_x, e_z, span_dx;
  logic signed [DW-1:0] sxf, exf;
  logic [WW-1:0] start_c, end_c;
  logic signed [DW-1:0] step_c;

  logic                 mul_start, mul_done;
  logic signed [DW-1:0] mul_a, mul_b, mul_p, mul_sh;
  logic                 div_start, div_done;
  logic signed [DW-1:0] div_n, div_d, div_q;

  logic [AW-1:0] pix_addr;
  logic          px_valid;
  logic [AW-1:0] px_addr;
  logic signed [DW-1:0] px_d;
  pix_t          rd_data;
  logic [32:0]   unp_prod;
  logic signed [DW-1:0] unp;
  logic          nearer;
  logic [F+16:0] pack_prod;
  logic [15:0]   pack_d;
  logic          clearing;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  pix_t          mem_wd;
  logic [AW-1:0] mem_ra;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
    w_s = DW'(eff_w);
    h_s = DW'(eff_h);
    thr = DW'(degenerate_threshold);
    clr_n = (WW+HW)'(eff_w) * (WW+HW)'(eff_h);
    rd_ext = {{AW{1'b0}}, read_index};
  end

  always_comb begin
    minx = vx[0];
    maxx = vx[0];
    miny = vy[0];
    maxy = vy[0];
    for (int k = 1; k < 3; k++) begin
      if (vx[k] < minx) minx = vx[k];
      if (vx[k] > maxx) maxx = vx[k];
      if (vy[k] < miny) miny = vy[k];
      if (vy[k] > maxy) maxy = vy[k];
    end
    bbox_out = (maxx < 0) || (minx >= (w_s <<< F)) || (maxy < 0) || (miny >= (h_s <<< F));
    sp = (state == ST_SORT2) ? 2'd1 : 2'd0;
    sq = (state == ST_SORT0) ? 2'd1 : 2'd2;
    do_swap = vy[sp] > vy[sq];
    dyt = vy[2] - vy[0];
    dytop = vy[1] - vy[0];
    dybot = vy[2] - vy[1];
  end

  always_comb begin
    ytop = vy[0] >>> F;
    h_ylo = half ? (vy[1] >>> F) : (vy[0] >>> F);
    h_yhi = half ? (vy[2] >>> F) : (vy[1] >>> F);
    h_rx = half ? vx[1] : vx[0];
    h_rz = half ? vz[1] : vz[0];
    h_dxr = half ? (vx[2] - vx[1]) : (vx[1] - vx[0]);
    h_dzr = half ? (vz[2] - vz[1]) : (vz[1] - vz[0]);
    h_bstep = half ? bstep_bot : bstep_top;
    y_lo_c = (h_ylo < 0) ? '0 : h_ylo;
    y_hi_c = (h_yhi > h_s) ? h_s : h_yhi;
  end

  always_comb begin
    if (sx > ex) begin
      s_x = ex;
      s_z = ez;
      e_x = sx;
      e_z = sz;
    end else begin
      s_x = sx;
      s_z = sz;
      e_x = ex;
      e_z = ez;
    end
    span_dx = e_x - s_x;
    sxf = sx >>> F;
    exf = ex >>> F;
    if (sxf < 0) begin
      start_c = '0;
    end else if (sxf > w_s) begin
      start_c = eff_w;
    end else begin
      start_c = WW'(sxf);
    end
    if (exf < 0) begin
      end_c = '0;
    end else if (exf > w_s) begin
      end_c = eff_w;
    end else begin
      end_c = WW'(exf);
    end
    if (div_q > STEP_LIM) begin
      step_c = STEP_LIM;
    end else if (div_q < -STEP_LIM) begin
      step_c = -STEP_LIM;
    end else begin
      step_c = div_q;
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MULA: begin
        mul_a = y_cur - ytop;
        mul_b = astep;
        mul_start = !op_wait;
      end
      ST_MULB: begin
        mul_a = y_cur - h_ylo;
        mul_b = h_bstep;
        mul_start = !op_wait;
      end
      ST_MSX: begin
        mul_a = vx[2] - vx[0];
        mul_b = alpha;
        mul_start = !op_wait;
      end
      ST_MSZ: begin
        mul_a = vz[2] - vz[0];
        mul_b = alpha;
        mul_start = !op_wait;
      end
      ST_MEX: begin
        mul_a = h_dxr;
        mul_b = beta;
        mul_start = !op_wait;
      end
      ST_MEZ: begin
        mul_a = h_dzr;
        mul_b = beta;
        mul_start = !op_wait;
      end
      ST_MULD: begin
        mul_a = step;
        mul_b = (DW'(i_cur) <<< F) - sx;
        mul_start = !op_wait;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
    mul_sh = mul_p >>> F;
  end

  always_comb begin
    div_start = 1'b0;
    div_n = DIV_ONE;
    div_d = dyt;
    case (state)
      ST_DIVA: begin
        div_start = !op_wait;
      end
      ST_DIVB: begin
        div_d = dytop;
        div_start = !op_wait && (dytop > thr);
      end
      ST_DIVC: begin
        div_d = dybot;
        div_start = !op_wait && (dybot > thr);
      end
      ST_DIVS: begin
        div_n = (ez - sz) <<< F;
        div_d = ex - sx;
        div_start = !op_wait;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  stdr_mul #(.W(DW)) u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a),
    .b(mul_b),
    .done(mul_done),
    .product(mul_p)
  );

  stdr_div #(.W(DW)) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_n),
    .divisor(div_d),
    .done(div_done),
    .quotient(div_q)
  );

  always_comb begin
    pix_addr = line_addr + AW'(i_cur);
    unp_prod = 33'(rd_data.depth) * 33'(UNPACK_MUL);
    if (rd_data.depth == DEPTH_FAR) begin
      unp = UNIT;
    end else begin
      unp = DW'(unp_prod >> (32 - F));
    end
    nearer = px_d < unp;
    pack_prod = (F+17)'(px_d[F-1:0]) * (F+17)'(PACK_MUL) + ((F+17)'(1) << (F - 1));
    if (px_d <= 0) begin
      pack_d = '0;
    end else if (px_d >= UNIT) begin
      pack_d = DEPTH_FAR;
    end else begin
      pack_d = 16'(pack_prod >> F);
    end
    clearing = (state == ST_INIT) || (state == ST_CLEAR);
    mem_we = clearing || (px_valid && nearer);
    mem_wa = clearing ? clr_cnt : px_addr;
    mem_wd.depth = clearing ? DEPTH_FAR : pack_d;
    mem_wd.color = clearing ? '0 : color;
    mem_ra = (state == ST_READ) ? rd_idx : pix_addr;
  end

  stdr_mem #(.DEPTH(STORE), .AW(AW)) u_mem (
    .clk(clk),
    .we(mem_we),
    .wr_addr(mem_wa),
    .wr_data(mem_wd),
    .rd_addr(mem_ra),
    .rd_data(rd_data)
  );

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    px_addr <= pix_addr;
    px_d <= d_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      op_wait <= 1'b0;
      half <= 1'b0;
      px_valid <= 1'b0;
      clr_cnt <= '0;
      clr_last <= AW'(STORE - 1);
      frame_width <= SIZE_RESET;
      frame_height <= SIZE_RESET;
      degenerate_threshold <= THR_RESET;
      read_color <= '0;
      read_depth <= '0;
      rejected <= 1'b0;
    end else begin
      px_valid <= (state == ST_PIX);
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH: frame_width <= cfg_data[6:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[6:0];
          REG_DEGEN_THR: degenerate_threshold <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            read_color <= '0;
            read_depth <= '0;
            rejected <= 1'b0;
            half <= 1'b0;
            op_wait <= 1'b0;
            color <= fill_color;
            rd_idx <= rd_ext[AW-1:0];
            rd_ok <= rd_ext < (AW+12)'(STORE);
            vx[0] <= {{32{vert_a_x[31]}}, vert_a_x[31:F], {F{1'b0}}};
            vy[0] <= {{32{vert_a_y[31]}}, vert_a_y[31:F], {F{1'b0}}};
            vz[0] <= {{32{vert_a_z[31]}}, vert_a_z};
            vx[1] <= {{32{vert_b_x[31]}}, vert_b_x[31:F], {F{1'b0}}};
            vy[1] <= {{32{vert_b_y[31]}}, vert_b_y[31:F], {F{1'b0}}};
            vz[1] <= {{32{vert_b_z[31]}}, vert_b_z};
            vx[2] <= {{32{vert_c_x[31]}}, vert_c_x[31:F], {F{1'b0}}};
            vy[2] <= {{32{vert_c_y[31]}}, vert_c_y[31:F], {F{1'b0}}};
            vz[2] <= {{32{vert_c_z[31]}}, vert_c_z};
            case (mode)
              MODE_CLEAR: begin
                clr_cnt <= '0;
                clr_last <= AW'(clr_n - 1'b1);
                state <= ST_CLEAR;
              end
              MODE_DRAW: state <= ST_BBOX;
              MODE_READ: state <= ST_READ;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_INIT, ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == clr_last) begin
            state <= (state == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_READ: state <= ST_RDCAP;
        ST_RDCAP: begin
          if (rd_ok) begin
            read_color <= rd_data.color;
            read_depth <= rd_data.depth;
          end
          state <= ST_DONE;
        end
        ST_BBOX: begin
          if (bbox_out) begin
            rejected <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_SORT0;
          end
        end
        ST_SORT0, ST_SORT1, ST_SORT2: begin
          if (do_swap) begin
            vx[sp] <= vx[sq];
            vy[sp] <= vy[sq];
            vz[sp] <= vz[sq];
            vx[sq] <= vx[sp];
            vy[sq] <= vy[sp];
            vz[sq] <= vz[sp];
          end
          state <= (state == ST_SORT0) ? ST_SORT1 :
                   (state == ST_SORT1) ? ST_SORT2 : ST_HEIGHT;
        end
        ST_HEIGHT: begin
          if (dyt < thr || dyt == 0) begin
            rejected <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_DIVA;
          end
        end
        ST_DIVA: begin
          if (!op_wait) begin
            op_wait <= 1'b1;
          end else if (div_done) begin
            op_wait <= 1'b0;
            astep <= div_q;
            state <= ST_DIVB;
          end
        end
        ST_DIVB: begin
          if (!op_wait) begin
            if (dytop > thr) begin
              op_wait <= 1'b1;
            end else begin
              bstep_top <= '0;
              state <= ST_DIVC;
            end
          end else if (div_done) begin
            op_wait <= 1'b0;
            bstep_top <= div_q;
            state <= ST_DIVC;
          end
        end
        ST_DIVC: begin
          if (!op_wait) begin
            if (dybot > thr) begin
              op_wait <= 1'b1;
            end else begin
              bstep_bot <= '0;
              state <= ST_HALF;
            end
          end else if (div_done) begin
            op_wait <= 1'b0;
            bstep_bot <= div_q;
            state <= ST_HALF;
          end
        end
        ST_HALF: begin
          if (y_lo_c < y_hi_c) begin
            y_cur <= y_lo_c;
            y_end <= y_hi_c;
            state <= ST_MULA;
          end else if (!half) begin
            half <= 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_MULA, ST_MULB, ST_MSX, ST_MSZ, ST_MEX, ST_MEZ, ST_MULD: begin
          if (!op_wait) begin
            op_wait <= 1'b1;
          end else if (mul_done) begin
            op_wait <= 1'b0;
            case (state)
              ST_MULA: begin
                alpha <= mul_p;
                state <= ST_MULB;
              end
              ST_MULB: begin
                beta <= mul_p;
                state <= ST_MSX;
              end
              ST_MSX: begin
                sx <= vx[0] + mul_sh;
                state <= ST_MSZ;
              end
              ST_MSZ: begin
                sz <= vz[0] + mul_sh;
                state <= ST_MEX;
              end
              ST_MEX: begin
                ex <= h_rx + mul_sh;
                state <= ST_MEZ;
              end
              ST_MEZ: begin
                ez <= h_rz + mul_sh;
                state <= ST_SPAN;
              end
              default: begin
                d_cur <= sz + mul_sh;
                line_addr <= AW'(y_cur[HW-1:0] * eff_w);
                state <= ST_PIX;
              end
            endcase
          end
        end
        ST_SPAN: begin
          if (span_dx < thr || span_dx == 0) begin
            state <= ST_NEXT;
          end else begin
            sx <= s_x;
            sz <= s_z;
            ex <= e_x;
            ez <= e_z;
            state <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (!op_wait) begin
            op_wait <= 1'b1;
          end else if (div_done) begin
            op_wait <= 1'b0;
            step <= step_c;
            state <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          i_cur <= start_c;
          i_end <= end_c;
          state <= (start_c >= end_c) ? ST_NEXT : ST_MULD;
        end
        ST_PIX: begin
          i_cur <= i_cur + 1'b1;
          d_cur <= d_cur + step;
          if (WW'(i_cur + 1'b1) == i_end) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (y_cur + 1 < y_end) begin
            y_cur <= y_cur + 1;
            state <= ST_MULA;
          end else if (!half) begin
            half <= 1'b1;
            state <= ST_HALF;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
